>>> sv/lzfbd_pkg.sv
package lzfbd_pkg;

  // Default history depth in bytes
  localparam int unsigned WINDOW_DEPTH_DEF = 4096;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned SIZE_W = 32;
  localparam int unsigned DIST_W = 12;
  localparam int unsigned TOK_W  = 4;
  localparam int unsigned LEN_W  = 5;

  localparam logic [TOK_W-1:0] TOKENS_PER_FLAG = 4'd8;
  localparam logic [LEN_W-1:0] MIN_MATCH       = 5'd3;
  localparam logic [BYTE_W-1:0] LEN_MASK       = 8'h0F;
  localparam logic [BYTE_W-1:0] HIGH_MASK      = 8'hF0;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DATA    = 3'd0,
    KIND_DONE    = 3'd1,
    KIND_TRUNC   = 3'd2,
    KIND_BEFORE  = 3'd3,
    KIND_OVERRUN = 3'd4,
    KIND_SHORT   = 3'd5
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_RD,
    S_WR,
    S_FIN
  } state_e;

  // Position compares from the count unit
  typedef struct packed {
    logic eq;        // count equals size
    logic gt;        // count above size
    logic next_eq;   // count plus one equals size
    logic below;     // count below the match offset
  } pos_stat_t;

endpackage

>>> sv/lzfbd_if.sv
interface lzfbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;
  logic       end_of_packed;

  modport source (output valid, output packed_byte, output end_of_packed, input ready);
  modport sink (input valid, input packed_byte, input end_of_packed, output ready);
endinterface

interface lzfbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [2:0] kind;
  logic       run_end;

  modport source (output valid, output out_byte, output kind, output run_end, input ready);
  modport sink (input valid, input out_byte, input kind, input run_end, output ready);
endinterface

>>> sv/lzfbd_hist.sv
module lzfbd_hist #(
  parameter int unsigned DEPTH = lzfbd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [7:0]               wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [7:0]               rdata_o
);
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  // Write one produced byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

>>> sv/lzfbd_pos.sv
module lzfbd_pos #(
  parameter int unsigned WINDOW_DEPTH = lzfbd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             inc_i,
  input  logic [lzfbd_pkg::SIZE_W-1:0]     size_i,
  input  logic [lzfbd_pkg::DIST_W-1:0]     dist_i,
  output lzfbd_pkg::pos_stat_t             stat_o,
  output logic [$clog2(WINDOW_DEPTH)-1:0]  wr_addr_o,
  output logic [$clog2(WINDOW_DEPTH)-1:0]  rd_addr_o
);
  import lzfbd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  logic [SIZE_W-1:0] cnt_q, cnt_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [SIZE_W:0]   cnt_inc;
  logic [AW:0]       diff;
  logic [AW:0]       wrapped;

  // Count produced bytes and track the write slot modulo the depth
  always_comb begin
    cnt_d = cnt_q;
    wp_d  = wp_q;
    if (inc_i) begin
      cnt_d = cnt_q + 1'b1;
      wp_d  = (wp_q == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wp_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      wp_q  <= wp_d;
    end
  end

  // Compare count against size and offset
  assign cnt_inc        = {1'b0, cnt_q} + 1'b1;
  assign stat_o.eq      = (cnt_q == size_i);
  assign stat_o.gt      = (cnt_q > size_i);
  assign stat_o.next_eq = (cnt_inc == {1'b0, size_i});
  assign stat_o.below   = (cnt_q < {{(SIZE_W-DIST_W){1'b0}}, dist_i});

  // Source slot: write slot minus offset, wrapped into the window
  assign diff      = {1'b0, wp_q} - {{(AW+1-DIST_W){1'b0}}, dist_i};
  assign wrapped   = diff + (AW+1)'(WINDOW_DEPTH);
  assign rd_addr_o = diff[AW] ? wrapped[AW-1:0] : diff[AW-1:0];
  assign wr_addr_o = wp_q;
endmodule

>>> sv/lzss_flag_byte_decompressor.sv
// Unpacks an LZSS stream with inline flag bytes, 12-bit offsets and 4-bit
// lengths, one packed byte per input word, into one unpacked byte per output
// word, followed by a single status word when unpacking stops (done, truncated
// match, offset before start, overrun or short output). Each input word is
// taken in S_IDLE and decoded in S_DEC; the second byte of a match sets up a
// copy of length 3 to 18, and each copied byte costs a read of the history
// memory in S_RD and then a write in S_WR, never both at once. The status
// word comes from S_DEC, S_RD or S_FIN. Output back-pressure stalls the block.
// After a stop every input word is taken and dropped until reset. The user
// must write expected_size only while the block is idle; nothing enforces it.
module lzss_flag_byte_decompressor #(
  parameter int unsigned WINDOW_DEPTH = lzfbd_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [lzfbd_pkg::SIZE_W-1:0] cfg_data_i,
  lzfbd_in_if.sink                     in_i,
  lzfbd_out_if.source                  out_o
);
  import lzfbd_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [7:0]        byte_q, byte_d;
  logic              last_q, last_d;
  logic [7:0]        flag_q, flag_d;
  logic [TOK_W-1:0]  tok_q, tok_d;
  logic [7:0]        mf_q, mf_d;
  logic              await_q, await_d;
  logic              failed_q, failed_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [LEN_W-1:0]  len_q, len_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  kind_e             out_kind_q, out_kind_d;
  logic              out_end_q, out_end_d;
  logic              out_load;
  logic              out_free;

  pos_stat_t         stat;
  logic              inc;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic              mem_we, mem_re;
  logic [7:0]        mem_wdata, mem_rdata;
  logic              accept;
  logic              end_due;

  lzfbd_pos #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_pos (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .inc_i     (inc),
    .size_i    (size_q),
    .dist_i    (dist_q),
    .stat_o    (stat),
    .wr_addr_o (wr_addr),
    .rd_addr_o (rd_addr)
  );

  lzfbd_hist #(.DEPTH(WINDOW_DEPTH)) u_hist (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_addr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (rd_addr),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign end_due    = stat.next_eq || last_q;

  // Sequencer: decode a token, then walk the copy one byte at a time
  always_comb begin
    state_d    = state_q;
    byte_d     = byte_q;
    last_d     = last_q;
    flag_d     = flag_q;
    tok_d      = tok_q;
    mf_d       = mf_q;
    await_d    = await_q;
    failed_d   = failed_q;
    dist_d     = dist_q;
    len_d      = len_q;
    out_load   = 1'b0;
    out_byte_d = out_byte_q;
    out_kind_d = out_kind_q;
    out_end_d  = out_end_q;
    inc        = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_wdata  = byte_q;

    case (state_q)
      S_IDLE: begin
        // Take a word; drop it once unpacking has stopped
        if (accept) begin
          byte_d = in_i.packed_byte;
          last_d = in_i.end_of_packed;
          if (!failed_q) begin
            state_d = S_DEC;
          end
        end
      end

      S_DEC: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (stat.eq || stat.gt) begin
            out_load   = 1'b1;
            out_byte_d = '0;
            out_kind_d = stat.eq ? KIND_DONE : KIND_OVERRUN;
            out_end_d  = 1'b1;
            failed_d   = 1'b1;
          end else if (tok_q == '0) begin
            // Flag byte
            flag_d = byte_q;
            tok_d  = TOKENS_PER_FLAG;
            if (last_q) begin
              out_load   = 1'b1;
              out_byte_d = '0;
              out_kind_d = KIND_SHORT;
              out_end_d  = 1'b1;
              failed_d   = 1'b1;
            end
          end else if (await_q) begin
            // Second match byte: set up the copy
            await_d = 1'b0;
            flag_d  = {flag_q[6:0], 1'b0};
            tok_d   = tok_q - 1'b1;
            len_d   = LEN_W'(mf_q & LEN_MASK) + MIN_MATCH;
            dist_d  = {mf_q[7:4], byte_q};
            state_d = S_RD;
          end else if (flag_q[7]) begin
            // First match byte
            if (last_q) begin
              out_load   = 1'b1;
              out_byte_d = '0;
              out_kind_d = KIND_TRUNC;
              out_end_d  = 1'b1;
              failed_d   = 1'b1;
            end else begin
              mf_d    = byte_q;
              await_d = 1'b1;
            end
          end else begin
            // Literal
            flag_d     = {flag_q[6:0], 1'b0};
            tok_d      = tok_q - 1'b1;
            mem_we     = 1'b1;
            mem_wdata  = byte_q;
            inc        = 1'b1;
            out_load   = 1'b1;
            out_byte_d = byte_q;
            out_kind_d = KIND_DATA;
            out_end_d  = !end_due;
            if (end_due) begin
              state_d = S_FIN;
            end
          end
        end
      end

      S_RD: begin
        // Check the next copy byte, then fetch its source
        if (stat.eq || stat.gt || stat.below) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_byte_d = '0;
            out_kind_d = stat.below && !(stat.eq || stat.gt) ? KIND_BEFORE : KIND_OVERRUN;
            out_end_d  = 1'b1;
            failed_d   = 1'b1;
            state_d    = S_IDLE;
          end
        end else begin
          mem_re  = 1'b1;
          state_d = S_WR;
        end
      end

      S_WR: begin
        // Emit and store the copied byte
        if (out_free) begin
          mem_wdata  = (dist_q == '0) ? '0 : mem_rdata;
          mem_we     = 1'b1;
          inc        = 1'b1;
          len_d      = len_q - 1'b1;
          out_load   = 1'b1;
          out_byte_d = mem_wdata;
          out_kind_d = KIND_DATA;
          if (len_q == LEN_W'(1)) begin
            out_end_d = !end_due;
            state_d   = end_due ? S_FIN : S_IDLE;
          end else begin
            out_end_d = 1'b0;
            state_d   = S_RD;
          end
        end
      end

      S_FIN: begin
        // Closing status after the last data byte
        if (out_free) begin
          out_load   = 1'b1;
          out_byte_d = '0;
          out_kind_d = stat.eq ? KIND_DONE : KIND_SHORT;
          out_end_d  = 1'b1;
          failed_d   = 1'b1;
          state_d    = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      size_q   <= '0;
      flag_q   <= '0;
      tok_q    <= '0;
      mf_q     <= '0;
      await_q  <= 1'b0;
      failed_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      flag_q   <= flag_d;
      tok_q    <= tok_d;
      mf_q     <= mf_d;
      await_q  <= await_d;
      failed_q <= failed_d;
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    dist_q <= dist_d;
    len_q  <= len_d;
  end

  // Output register: load when free, drop when taken
  assign out_valid_d = out_load ? 1'b1 : (out_o.ready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_byte_q <= out_byte_d;
      out_kind_q <= out_kind_d;
      out_end_q  <= out_end_d;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.kind     = out_kind_q;
  assign out_o.run_end  = out_end_q;

`ifndef NO_ASSERTIONS
  a_quiet_after_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    failed_q |=> !out_load)
    else $error("word produced after unpacking stopped");

  a_status_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_kind_d != KIND_DATA) |=> (failed_q && out_o.run_end))
    else $error("status word did not stop unpacking or end its run");

  a_copy_len_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_WR) |-> (len_q != '0))
    else $error("copy walking with no bytes left");

  a_no_mem_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_we && mem_re))
    else $error("history read and write in one cycle");
`endif
endmodule
